### rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes of the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 6;

    localparam logic [CMD_W-1:0] CMD_ADD_FRONT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD_BACK     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_REMOVE_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LIST_FWD     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LIST_REV     = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // one result beat
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } deq_res_t;

    // output buffer state seen by the sequencer
    typedef struct packed {
        logic [1:0] occ;
        logic       pop;
    } deq_obuf_t;

endpackage

### rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Command sequencer: ring indices, entry count, RAM access and list walk.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [deq_pkg::CMD_W-1:0]           in_cmd,
    input  logic [deq_pkg::VALUE_W-1:0]         in_value,
    input  deq_pkg::deq_obuf_t                  obuf,
    output logic                                res_valid,
    output deq_pkg::deq_res_t                   res,
    output logic                                ram_we,
    output logic [$clog2(DEPTH)-1:0]            ram_waddr,
    output logic [deq_pkg::VALUE_W-1:0]         ram_wdata,
    output logic                                ram_re,
    output logic [$clog2(DEPTH)-1:0]            ram_raddr,
    input  logic [deq_pkg::VALUE_W-1:0]         ram_rdata
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic                       state_reg, state_next;
    logic [IW-1:0]              front_reg, front_next;
    logic [IW-1:0]              back_reg, back_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [IW-1:0]              ptr_reg, ptr_next;
    logic [CW-1:0]              left_reg, left_next;
    logic                       dir_rev_reg, dir_rev_next;
    logic                       pend_reg, pend_next;
    logic                       pend_mem_reg, pend_mem_next;
    deq_pkg::deq_res_t          pend_meta_reg, pend_meta_next;

    logic [2:0]                 credit;
    logic                       can_issue;
    logic                       full, empty;

    function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
    endfunction

    function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] p);
        return (p == '0) ? IW'(DEPTH - 1) : p - IW'(1);
    endfunction

    // room in the output buffer for everything in flight
    assign credit    = {1'b0, obuf.occ} + {2'b0, pend_reg} - {2'b0, obuf.pop};
    assign can_issue = (credit < 3'd2);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign in_ready  = (state_reg == S_IDLE) && can_issue;

    always_comb begin
        state_next     = state_reg;
        front_next     = front_reg;
        back_next      = back_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        dir_rev_next   = dir_rev_reg;
        pend_next      = 1'b0;
        pend_mem_next  = 1'b0;
        pend_meta_next = pend_meta_reg;
        ram_we         = 1'b0;
        ram_waddr      = back_reg;
        ram_wdata      = in_value;
        ram_re         = 1'b0;
        ram_raddr      = front_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    pend_next             = 1'b1;
                    pend_meta_next.value  = '0;
                    pend_meta_next.status = deq_pkg::STAT_OK;
                    pend_meta_next.last   = 1'b1;
                    case (in_cmd)
                        deq_pkg::CMD_ADD_FRONT: begin
                            if (full) begin
                                pend_meta_next.status = deq_pkg::STAT_FULL;
                            end else begin
                                front_next = idx_dec(front_reg);
                                ram_we     = 1'b1;
                                ram_waddr  = idx_dec(front_reg);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        deq_pkg::CMD_ADD_BACK: begin
                            if (full) begin
                                pend_meta_next.status = deq_pkg::STAT_FULL;
                            end else begin
                                back_next  = idx_inc(back_reg);
                                ram_we     = 1'b1;
                                ram_waddr  = back_reg;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        deq_pkg::CMD_REMOVE_FRONT: begin
                            if (empty) begin
                                pend_meta_next.status = deq_pkg::STAT_EMPTY;
                            end else begin
                                ram_re        = 1'b1;
                                ram_raddr     = front_reg;
                                front_next    = idx_inc(front_reg);
                                count_next    = count_reg - CW'(1);
                                pend_mem_next = 1'b1;
                            end
                        end
                        deq_pkg::CMD_REMOVE_BACK: begin
                            if (empty) begin
                                pend_meta_next.status = deq_pkg::STAT_EMPTY;
                            end else begin
                                ram_re        = 1'b1;
                                ram_raddr     = idx_dec(back_reg);
                                back_next     = idx_dec(back_reg);
                                count_next    = count_reg - CW'(1);
                                pend_mem_next = 1'b1;
                            end
                        end
                        deq_pkg::CMD_LIST_FWD,
                        deq_pkg::CMD_LIST_REV: begin
                            if (empty) begin
                                pend_meta_next.status = deq_pkg::STAT_EMPTY;
                            end else begin
                                pend_next    = 1'b0;
                                state_next   = S_LIST;
                                left_next    = count_reg;
                                dir_rev_next = (in_cmd == deq_pkg::CMD_LIST_REV);
                                ptr_next     = (in_cmd == deq_pkg::CMD_LIST_REV) ?
                                               idx_dec(back_reg) : front_reg;
                            end
                        end
                        default: begin
                        end
                    endcase
                    pend_meta_next.count = deq_pkg::COUNT_W'(count_next);
                end
            end
            S_LIST: begin
                if (can_issue) begin
                    ram_re                = 1'b1;
                    ram_raddr             = ptr_reg;
                    pend_next             = 1'b1;
                    pend_mem_next         = 1'b1;
                    pend_meta_next.value  = '0;
                    pend_meta_next.status = deq_pkg::STAT_OK;
                    pend_meta_next.count  = deq_pkg::COUNT_W'(count_reg);
                    pend_meta_next.last   = (left_reg == CW'(1));
                    ptr_next  = dir_rev_reg ? idx_dec(ptr_reg) : idx_inc(ptr_reg);
                    left_next = left_reg - CW'(1);
                    if (left_reg == CW'(1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        left_reg      <= left_next;
        dir_rev_reg   <= dir_rev_next;
        pend_mem_reg  <= pend_mem_next;
        pend_meta_reg <= pend_meta_next;
    end

    always_comb begin
        res       = pend_meta_reg;
        res.value = pend_mem_reg ? ram_rdata : '0;
    end
    assign res_valid = pend_reg;

    // ring bookkeeping: back is always front plus count, modulo depth
    logic [IW:0] ring_sum;
    logic [IW:0] ring_wrap;
    assign ring_sum  = (IW + 1)'(front_reg) + (IW + 1)'(count_reg);
    assign ring_wrap = (ring_sum >= (IW + 1)'(DEPTH)) ?
                       ring_sum - (IW + 1)'(DEPTH) : ring_sum;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_ring_consistent: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_wrap[IW-1:0] == back_reg)
        else $error("front, back and count disagree");

    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("RAM read and write in one cycle");

    a_list_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |-> (left_reg != '0) && !in_ready)
        else $error("list walk with nothing left or input open");

    a_list_ends_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST && state_next == S_IDLE) |=> (pend_reg && pend_meta_reg.last))
        else $error("list walk ended without a last beat");

endmodule

### rtl/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit values held in a ring RAM.
// ----------------------------------------------------------------------------
// Input beats (s_) carry a command and a value: add front/back, remove
// front/back, list forward/reverse. Result beats (m_) carry the removed or
// listed value, a status (ok, empty, full) and the entry count after the
// command; m_tlast marks the final result of a command.
// Add, remove and unknown commands give one result each; a listing gives
// one result per stored value and holds s_tready low until the walk ends,
// one RAM read per cycle while the output buffer has room. A result is
// registered in the controller and then in the output buffer.
// A two-entry output buffer decouples the sides: with m_tready high the
// unit sustains one beat per cycle; when the receiver stalls, the buffer
// fills and s_tready drops (or the listing pauses) until beats drain.
// Reset (aresetn low, synchronous) empties the queue and the output buffer;
// the RAM contents are not cleared and no entry is read before it is
// written.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // command[2:0], item_value[34:3], zero[39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,  // out_value[31:0], status[33:32], entry_count[39:34]
    output logic        m_tlast
);

    localparam int IW = $clog2(DEPTH);

    logic                         ram_we;
    logic [IW-1:0]                ram_waddr;
    logic [deq_pkg::VALUE_W-1:0]  ram_wdata;
    logic                         ram_re;
    logic [IW-1:0]                ram_raddr;
    logic [deq_pkg::VALUE_W-1:0]  ram_rdata;

    logic                         res_valid;
    deq_pkg::deq_res_t            res;
    deq_pkg::deq_obuf_t           obuf;

    logic [1:0]                   occ_reg;
    deq_pkg::deq_res_t            ent0_reg;
    deq_pkg::deq_res_t            ent1_reg;
    logic                         pop;
    logic [1:0]                   push_slot;

    deq_ram #(
        .WIDTH (deq_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    deq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tdata[2:0]),
        .in_value  (s_tdata[34:3]),
        .obuf      (obuf),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // two-entry output buffer, ent0 drives the master side
    assign pop       = m_tvalid && m_tready;
    assign push_slot = occ_reg - {1'b0, pop};
    assign obuf      = {occ_reg, pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_reg + {1'b0, res_valid} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && push_slot == 2'd0) begin
            ent0_reg <= res;
        end else if (pop) begin
            ent0_reg <= ent1_reg;
        end
        if (res_valid && push_slot != 2'd0) begin
            ent1_reg <= res;
        end
    end

    assign m_tvalid = (occ_reg != '0);
    assign m_tdata  = {ent0_reg.count, ent0_reg.status, ent0_reg.value};
    assign m_tlast  = ent0_reg.last;

    a_obuf_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg <= 2'd2) && !(res_valid && occ_reg == 2'd2 && !pop))
        else $error("output buffer overflow");

endmodule
